// ===== hdl/dsdcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dsdcs_pkg;

    localparam int unsigned SAMPLE_COUNT_WIDTH_DEFAULT = 16;

    localparam logic [31:0] SELFTEST_MS      = 32'd5000;
    localparam logic [31:0] END_MARGIN_MS    = 32'd2000;
    localparam logic [31:0] RESTART_WAIT_MS  = 32'd5000;
    localparam logic [31:0] TIMEOUT_SLACK_MS = 32'd100;
    localparam logic [7:0]  FAIL_LIMIT       = 8'd2;

    typedef enum logic [3:0] {
        PH_POWERON   = 4'd0,
        PH_STARTUP   = 4'd1,
        PH_POST      = 4'd2,
        PH_OFF       = 4'd3,
        PH_HWRESTART = 4'd4,
        PH_HWCLEANUP = 4'd5,
        PH_START     = 4'd6,
        PH_WARMUP    = 4'd7,
        PH_READ      = 4'd8,
        PH_READING   = 4'd9,
        PH_STOP      = 4'd10,
        PH_AFTER     = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_UPLOAD = 2'd1,
        ACT_INIT   = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_START   = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_VERSION = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        EXP_NONE = 2'd0,
        EXP_OFF  = 2'd1,
        EXP_ON   = 2'd2
    } expander_t;

    typedef enum logic [1:0] {
        REG_WARMUP   = 2'd0,
        REG_READ     = 2'd1,
        REG_WATCHDOG = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_A,
        ST_DIV_B,
        ST_OUT0,
        ST_OUT1
    } ctrl_state_t;

    typedef struct packed {
        command_t  cmd;
        expander_t exp;
        logic      valid;
        logic      failed;
    } result_flags_t;

endpackage

`default_nettype wire

// ===== hdl/dsdcs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsdcs_divider #(
    parameter int unsigned SAMPLE_COUNT_WIDTH = dsdcs_pkg::SAMPLE_COUNT_WIDTH_DEFAULT
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [31:0]                   dividend,
    input  wire [SAMPLE_COUNT_WIDTH-1:0] divisor,
    output logic                         done,
    output logic [31:0]                  quotient
);

    logic [31:0]                   quo_reg, quo_next;
    logic [SAMPLE_COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [SAMPLE_COUNT_WIDTH-1:0] dvs_reg, dvs_next;
    logic [5:0]                    cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [SAMPLE_COUNT_WIDTH:0]   trial;
    logic [SAMPLE_COUNT_WIDTH:0]   diff;

    always_comb begin
        trial      = {rem_reg, quo_reg[31]};
        diff       = trial - {1'b0, dvs_reg};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[SAMPLE_COUNT_WIDTH-1:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[SAMPLE_COUNT_WIDTH-1:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/dust_sensor_duty_cycle_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tuser action, s_tdata event fields
// m_        out        m_tvalid / m_tready  m_tdata result fields, m_tlast
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item is evaluated in the cycle after acceptance; each result is then
// held on m_tdata until m_tready takes it. A cycle close with readings runs
// the shared bit-serial divider twice, for the pm10 and pm25 averages. Reset
// is synchronous and active low. s_tready is low until every result of the
// item has been taken.

module dust_sensor_duty_cycle_sequencer #(
    parameter int unsigned SAMPLE_COUNT_WIDTH = dsdcs_pkg::SAMPLE_COUNT_WIDTH_DEFAULT
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // [1:0] action
    input  wire  [1:0]   s_tuser,
    // [31:0] now_ms, [63:32] time_to_measure_ms, [64] reading_valid,
    // [80:65] pm10_raw, [96:81] pm25_raw, [97] expander_nack, rest zero
    input  wire  [103:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [1:0] sensor_command, [3:2] expander_write, [4] result_valid,
    // [5] result_failed, [21:6] pm10_average, [37:22] pm25_average,
    // [41:38] cycle_phase, [73:42] cycles_closed, [105:74] cycles_failed
    output logic [111:0] m_tdata,
    output logic         m_tlast,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [1:0]   cfg_index,
    input  wire  [19:0]  cfg_data
);

    localparam logic [SAMPLE_COUNT_WIDTH-1:0] CountMax = '1;

    dsdcs_pkg::ctrl_state_t st_reg, st_next;

    logic [19:0] warmup_reg, read_reg;
    logic        wdog_reg;

    logic [1:0]  act_reg;
    logic [31:0] now_reg, ttm_reg;
    logic        rv_reg, nack_reg;
    logic [15:0] pm10_reg, pm25_reg;

    dsdcs_pkg::phase_t             phase_reg, phase_next;
    logic [31:0]                   entered_reg, entered_next;
    logic [31:0]                   tot10_reg, tot10_next, tot25_reg, tot25_next;
    logic [SAMPLE_COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [7:0]                    cf_reg, cf_next;
    logic [31:0]                   closed_reg, closed_next, failed_reg, failed_next;

    dsdcs_pkg::result_flags_t      r0_reg, r0_next, r1_reg, r1_next;
    logic                          two_reg, two_next;
    logic                          slot_reg, slot_next;
    logic                          need_div;
    logic [15:0]                   avg10_reg, avg25_reg;

    dsdcs_pkg::result_flags_t      t0, t1;
    logic [31:0]                   elapsed;
    logic [31:0]                   off_limit, warm_limit;

    logic                          div_start, div_done;
    logic [31:0]                   div_dividend, div_q;
    logic [SAMPLE_COUNT_WIDTH-1:0] div_divisor;
    logic [15:0]                   div_clamped;

    dsdcs_divider #(
        .SAMPLE_COUNT_WIDTH(SAMPLE_COUNT_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_q)
    );

    assign div_clamped = (div_q[31:16] != 16'd0) ? 16'hFFFF : div_q[15:0];
    assign elapsed     = now_reg + dsdcs_pkg::TIMEOUT_SLACK_MS - entered_reg;
    assign off_limit   = {12'd0, warmup_reg} + {12'd0, read_reg} + dsdcs_pkg::END_MARGIN_MS;
    assign warm_limit  = {12'd0, read_reg} + dsdcs_pkg::END_MARGIN_MS;

    always_comb begin
        logic [31:0] s10, s25;
        logic        do_store, do_close;
        logic [31:0] closed_base, failed_base;
        phase_next  = phase_reg;
        tot10_next  = tot10_reg;
        tot25_next  = tot25_reg;
        cnt_next    = cnt_reg;
        cf_next     = cf_reg;
        closed_base = (act_reg == dsdcs_pkg::ACT_INIT) ? 32'd0 : closed_reg;
        failed_base = (act_reg == dsdcs_pkg::ACT_INIT) ? 32'd0 : failed_reg;
        closed_next = closed_base;
        failed_next = failed_base;
        t0          = '0;
        t1          = '0;
        do_store    = 1'b0;
        do_close    = 1'b0;
        need_div    = 1'b0;
        case (phase_reg)
            dsdcs_pkg::PH_POWERON: phase_next = dsdcs_pkg::PH_STARTUP;
            dsdcs_pkg::PH_STARTUP: begin
                t0.cmd     = dsdcs_pkg::CMD_START;
                t1.cmd     = dsdcs_pkg::CMD_VERSION;
                tot10_next = '0;
                tot25_next = '0;
                cnt_next   = '0;
                phase_next = dsdcs_pkg::PH_POST;
            end
            dsdcs_pkg::PH_POST: begin
                do_store = 1'b1;
                if (elapsed > dsdcs_pkg::SELFTEST_MS) begin
                    do_close   = 1'b1;
                    t0.cmd     = dsdcs_pkg::CMD_STOP;
                    phase_next = dsdcs_pkg::PH_OFF;
                end
            end
            dsdcs_pkg::PH_OFF: begin
                if (wdog_reg && cf_reg > dsdcs_pkg::FAIL_LIMIT) begin
                    t0.exp = dsdcs_pkg::EXP_OFF;
                    if (!nack_reg) begin
                        phase_next = dsdcs_pkg::PH_HWRESTART;
                    end
                end else if (ttm_reg < off_limit) begin
                    phase_next = dsdcs_pkg::PH_START;
                end
            end
            dsdcs_pkg::PH_HWRESTART: begin
                if (elapsed > dsdcs_pkg::RESTART_WAIT_MS) begin
                    t0.exp = dsdcs_pkg::EXP_ON;
                    if (!nack_reg) begin
                        cf_next    = 8'd0;
                        phase_next = dsdcs_pkg::PH_HWCLEANUP;
                    end
                end
            end
            dsdcs_pkg::PH_HWCLEANUP: begin
                if (elapsed > dsdcs_pkg::RESTART_WAIT_MS) begin
                    t0.cmd     = dsdcs_pkg::CMD_STOP;
                    phase_next = dsdcs_pkg::PH_OFF;
                end
            end
            dsdcs_pkg::PH_START: begin
                t0.cmd     = dsdcs_pkg::CMD_START;
                phase_next = dsdcs_pkg::PH_WARMUP;
            end
            dsdcs_pkg::PH_WARMUP: begin
                if (ttm_reg < warm_limit) begin
                    phase_next = dsdcs_pkg::PH_READ;
                end
            end
            dsdcs_pkg::PH_READ: begin
                tot10_next = '0;
                tot25_next = '0;
                cnt_next   = '0;
                phase_next = dsdcs_pkg::PH_READING;
            end
            dsdcs_pkg::PH_READING: begin
                do_store = 1'b1;
                if (elapsed > {12'd0, read_reg}) begin
                    phase_next = dsdcs_pkg::PH_STOP;
                end
            end
            dsdcs_pkg::PH_STOP: begin
                do_close   = 1'b1;
                t0.cmd     = dsdcs_pkg::CMD_STOP;
                phase_next = dsdcs_pkg::PH_AFTER;
            end
            default: ;
        endcase

        s10 = tot10_reg + {16'd0, pm10_reg};
        s25 = tot25_reg + {16'd0, pm25_reg};
        if (do_store && rv_reg && cnt_reg != CountMax) begin
            tot10_next = (s10 < tot10_reg) ? 32'hFFFF_FFFF : s10;
            tot25_next = (s25 < tot25_reg) ? 32'hFFFF_FFFF : s25;
            cnt_next   = cnt_reg + SAMPLE_COUNT_WIDTH'(1);
        end
        if (do_close) begin
            t0.valid = 1'b1;
            if (closed_base != 32'hFFFF_FFFF) closed_next = closed_base + 32'd1;
            if (cnt_next != '0) begin
                need_div = 1'b1;
                cf_next  = 8'd0;
            end else begin
                t0.failed = 1'b1;
                if (cf_reg != 8'hFF) cf_next = cf_reg + 8'd1;
                if (failed_base != 32'hFFFF_FFFF) failed_next = failed_base + 32'd1;
            end
        end
    end

    always_comb begin
        dsdcs_pkg::phase_t ph_sel;
        r0_next   = '0;
        r1_next   = '0;
        two_next  = 1'b0;
        slot_next = 1'b0;
        ph_sel    = phase_reg;
        case (act_reg)
            dsdcs_pkg::ACT_TICK: begin
                r0_next  = t0;
                r1_next  = t1;
                ph_sel   = phase_next;
                two_next = (phase_reg == dsdcs_pkg::PH_STARTUP);
            end
            dsdcs_pkg::ACT_UPLOAD: begin
                if (phase_reg == dsdcs_pkg::PH_AFTER) ph_sel = dsdcs_pkg::PH_OFF;
            end
            dsdcs_pkg::ACT_INIT: begin
                ph_sel   = phase_next;
                two_next = 1'b1;
                if (phase_reg == dsdcs_pkg::PH_STARTUP) begin
                    r0_next = t0;
                    r1_next = t1;
                end else begin
                    r0_next.cmd = dsdcs_pkg::CMD_START;
                    r1_next     = t0;
                    slot_next   = 1'b1;
                    if (t0.cmd == dsdcs_pkg::CMD_NONE) r1_next.cmd = dsdcs_pkg::CMD_VERSION;
                end
            end
            dsdcs_pkg::ACT_STOP: r0_next.cmd = dsdcs_pkg::CMD_STOP;
            default: ;
        endcase
        entered_next = (ph_sel != phase_reg) ? now_reg : entered_reg;
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            dsdcs_pkg::ST_IDLE:  if (s_tvalid) st_next = dsdcs_pkg::ST_EVAL;
            dsdcs_pkg::ST_EVAL: begin
                if (need_div && (act_reg == dsdcs_pkg::ACT_TICK
                                 || act_reg == dsdcs_pkg::ACT_INIT)) begin
                    st_next = dsdcs_pkg::ST_DIV_A;
                end else begin
                    st_next = dsdcs_pkg::ST_OUT0;
                end
            end
            dsdcs_pkg::ST_DIV_A: if (div_done) st_next = dsdcs_pkg::ST_DIV_B;
            dsdcs_pkg::ST_DIV_B: if (div_done) st_next = dsdcs_pkg::ST_OUT0;
            dsdcs_pkg::ST_OUT0: begin
                if (m_tready) st_next = two_reg ? dsdcs_pkg::ST_OUT1 : dsdcs_pkg::ST_IDLE;
            end
            dsdcs_pkg::ST_OUT1:  if (m_tready) st_next = dsdcs_pkg::ST_IDLE;
            default:             st_next = dsdcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_tlast      = 1'b0;
        div_start    = 1'b0;
        div_dividend = tot10_next;
        div_divisor  = cnt_reg;
        case (st_reg)
            dsdcs_pkg::ST_IDLE: s_tready = 1'b1;
            dsdcs_pkg::ST_EVAL: begin
                div_divisor = cnt_next;
                div_start   = need_div && (act_reg == dsdcs_pkg::ACT_TICK
                                           || act_reg == dsdcs_pkg::ACT_INIT);
            end
            dsdcs_pkg::ST_DIV_A: begin
                div_start    = div_done;
                div_dividend = tot25_reg;
            end
            dsdcs_pkg::ST_OUT0: begin
                m_tvalid = 1'b1;
                m_tlast  = !two_reg;
            end
            dsdcs_pkg::ST_OUT1: begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
            end
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= dsdcs_pkg::ST_IDLE;
            warmup_reg  <= 20'd15000;
            read_reg    <= 20'd5000;
            wdog_reg    <= 1'b0;
            phase_reg   <= dsdcs_pkg::PH_POWERON;
            entered_reg <= '0;
            tot10_reg   <= '0;
            tot25_reg   <= '0;
            cnt_reg     <= '0;
            cf_reg      <= '0;
            closed_reg  <= '0;
            failed_reg  <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid) begin
                case (cfg_index)
                    dsdcs_pkg::REG_WARMUP:   warmup_reg <= cfg_data;
                    dsdcs_pkg::REG_READ:     read_reg   <= cfg_data;
                    dsdcs_pkg::REG_WATCHDOG: wdog_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (st_reg == dsdcs_pkg::ST_EVAL) begin
                entered_reg <= entered_next;
                case (act_reg)
                    dsdcs_pkg::ACT_TICK, dsdcs_pkg::ACT_INIT: begin
                        phase_reg  <= phase_next;
                        tot10_reg  <= tot10_next;
                        tot25_reg  <= tot25_next;
                        cnt_reg    <= cnt_next;
                        cf_reg     <= cf_next;
                        closed_reg <= closed_next;
                        failed_reg <= failed_next;
                    end
                    dsdcs_pkg::ACT_UPLOAD: begin
                        if (phase_reg == dsdcs_pkg::PH_AFTER) phase_reg <= dsdcs_pkg::PH_OFF;
                    end
                    default: ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            act_reg  <= s_tuser;
            now_reg  <= s_tdata[31:0];
            ttm_reg  <= s_tdata[63:32];
            rv_reg   <= s_tdata[64];
            pm10_reg <= s_tdata[80:65];
            pm25_reg <= s_tdata[96:81];
            nack_reg <= s_tdata[97];
        end
        if (st_reg == dsdcs_pkg::ST_EVAL) begin
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            two_reg   <= two_next;
            slot_reg  <= slot_next;
            avg10_reg <= 16'd0;
            avg25_reg <= 16'd0;
        end
        if (st_reg == dsdcs_pkg::ST_DIV_A && div_done) avg10_reg <= div_clamped;
        if (st_reg == dsdcs_pkg::ST_DIV_B && div_done) avg25_reg <= div_clamped;
    end

    always_comb begin
        dsdcs_pkg::result_flags_t f;
        logic                     with_avg;
        f        = (st_reg == dsdcs_pkg::ST_OUT1) ? r1_reg : r0_reg;
        with_avg = (st_reg == dsdcs_pkg::ST_OUT1) == slot_reg && f.valid && !f.failed;
        m_tdata  = {6'd0, failed_reg, closed_reg, phase_reg,
                    with_avg ? avg25_reg : 16'd0, with_avg ? avg10_reg : 16'd0,
                    f.failed, f.valid, f.exp, f.cmd};
    end

endmodule

`default_nettype wire
